### rtl/core/p2br_pkg.sv
// Shared constants, payload types and helper functions of the bilinear resampler.
package p2br_pkg;

   // Source memory geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = XW + YW;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   // Field widths
   localparam int POS_W   = 8;
   localparam int DIM_W   = 9;
   localparam int CHAN_W  = 16;
   localparam int OUT_W   = 8;
   localparam int NCHAN   = 4;
   localparam int PIX_W   = NCHAN * CHAN_W;

   // Derived arithmetic widths
   localparam int LOG_W   = $clog2(XW + 1);
   localparam int SHIFT_W = $clog2(XW + YW + 1);
   localparam int TX_W    = POS_W + DIM_W;
   localparam int GX_W    = XW + 1;
   localparam int GY_W    = YW + 1;
   localparam int WT_W    = XW + YW + 1;
   localparam int ACC_W   = CHAN_W + XW + YW;
   localparam int MUL_W   = CHAN_W + WT_W;

   // Four neighbours per blend
   localparam int TAPS  = 4;
   localparam int TAP_W = $clog2(TAPS);

   localparam int ASPECT_SHIFT = 3;
   localparam int DIV_SHIFT    = 8;
   localparam logic [OUT_W-1:0] CHAN_MAX = 8'd255;

   // Item actions
   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_ALPHA  = 2'd2;

   typedef struct packed {
      logic              action;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
      logic [CHAN_W-1:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] out_red;
      logic [OUT_W-1:0] out_green;
      logic [OUT_W-1:0] out_blue;
      logic [OUT_W-1:0] out_alpha;
      logic             has_cutout_alpha;
      logic             has_partial_alpha;
      logic             is_last_pixel;
      logic             coord_error;
   } rsp_type;

   typedef logic [TAPS-1:0][WT_W-1:0]   weight_vec_type;
   typedef logic [TAPS-1:0][ADDR_W-1:0] addr_vec_type;

   typedef struct packed {
      logic               coord_error;
      logic               is_last;
      logic [SHIFT_W-1:0] shift;
      addr_vec_type       addr;
      weight_vec_type     weight;
   } geom_type;

   typedef struct packed {
      logic               clear;
      logic               rd_valid;
      logic [TAP_W-1:0]   rd_tap;
      logic [SHIFT_W-1:0] shift;
   } blend_ctl_type;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
      logic [OUT_W-1:0] alpha;
   } pix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEOM,
      ST_WEIGHT,
      ST_READ,
      ST_FINISH
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [LOG_W-1:0] floor_log2(input logic [DIM_W-1:0] v);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int i = 1; i < DIM_W; i++) begin
         if (v[i]) k = LOG_W'(i);
      end
      return k;
   endfunction

endpackage

### rtl/core/p2br_ram.sv
// Generic single-port synchronous RAM with registered read data.
module p2br_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/p2br_addr.sv
// Two-stage address and weight generator: output size, source position, taps.
module p2br_addr (
   input  logic                       clock,
   input  logic [p2br_pkg::POS_W-1:0] pos_x,
   input  logic [p2br_pkg::POS_W-1:0] pos_y,
   input  logic [p2br_pkg::DIM_W-1:0] source_width,
   input  logic [p2br_pkg::DIM_W-1:0] source_height,
   output p2br_pkg::geom_type         geom
);
   import p2br_pkg::*;

   // Stage one: output size and scaled coordinates
   logic [DIM_W-1:0] sw_in, sh_in, ow_in, oh_in;
   logic [LOG_W-1:0] kx0, ky0, kx_in, ky_in;
   logic [TX_W-1:0]  tx_in, ty_in;
   logic             err_in, last_in;

   logic [DIM_W-1:0] sw_ff, sh_ff, ow_ff, oh_ff;
   logic [LOG_W-1:0] kx_ff, ky_ff;
   logic [TX_W-1:0]  tx_ff, ty_ff;
   logic             err_ff, last_ff;

   // Stage two: neighbours and weights
   logic [XW-1:0]   ix, ix1, fx;
   logic [YW-1:0]   iy, iy1, fy;
   logic [GX_W-1:0] gx;
   logic [GY_W-1:0] gy;
   geom_type        geom_in;
   geom_type        geom_ff;

   always_comb begin
      sw_in = clamp_dim(source_width, DIM_W'(MAX_WIDTH));
      sh_in = clamp_dim(source_height, DIM_W'(MAX_HEIGHT));
      kx0   = floor_log2(sw_in);
      ky0   = floor_log2(sh_in);
      kx_in = kx0;
      ky_in = ky0;
      // Limit the aspect ratio to 8:1, height checked first
      if ((ky0 >= LOG_W'(ASPECT_SHIFT)) && ((ky0 - LOG_W'(ASPECT_SHIFT)) > kx0)) begin
         ky_in = kx0 + LOG_W'(ASPECT_SHIFT);
      end else if ((kx0 >= LOG_W'(ASPECT_SHIFT)) &&
                   ((kx0 - LOG_W'(ASPECT_SHIFT)) > ky0)) begin
         kx_in = ky0 + LOG_W'(ASPECT_SHIFT);
      end
      ow_in   = DIM_W'(1) << kx_in;
      oh_in   = DIM_W'(1) << ky_in;
      tx_in   = TX_W'(pos_x) * TX_W'(sw_in);
      ty_in   = TX_W'(pos_y) * TX_W'(sh_in);
      err_in  = (DIM_W'(pos_x) >= ow_in) || (DIM_W'(pos_y) >= oh_in);
      last_in = (DIM_W'(pos_x) == (ow_in - DIM_W'(1))) &&
                (DIM_W'(pos_y) == (oh_in - DIM_W'(1)));
   end

   always_ff @(posedge clock) begin
      sw_ff   <= sw_in;
      sh_ff   <= sh_in;
      ow_ff   <= ow_in;
      oh_ff   <= oh_in;
      kx_ff   <= kx_in;
      ky_ff   <= ky_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   always_comb begin
      ix = XW'(tx_ff >> kx_ff);
      iy = YW'(ty_ff >> ky_ff);
      fx = XW'(tx_ff & TX_W'(ow_ff - DIM_W'(1)));
      fy = YW'(ty_ff & TX_W'(oh_ff - DIM_W'(1)));
      gx = GX_W'(ow_ff) - GX_W'(fx);
      gy = GY_W'(oh_ff) - GY_W'(fy);
      // Clamp the right and lower neighbours to the last column and row
      if ((GX_W'(ix) + GX_W'(1)) < GX_W'(sw_ff)) begin
         ix1 = ix + XW'(1);
      end else begin
         ix1 = XW'(sw_ff - DIM_W'(1));
      end
      if ((GY_W'(iy) + GY_W'(1)) < GY_W'(sh_ff)) begin
         iy1 = iy + YW'(1);
      end else begin
         iy1 = YW'(sh_ff - DIM_W'(1));
      end
      geom_in.coord_error = err_ff;
      geom_in.is_last     = last_ff;
      geom_in.shift       = SHIFT_W'(kx_ff) + SHIFT_W'(ky_ff);
      geom_in.addr[0]     = {iy, ix};
      geom_in.addr[1]     = {iy, ix1};
      geom_in.addr[2]     = {iy1, ix};
      geom_in.addr[3]     = {iy1, ix1};
      geom_in.weight[0]   = WT_W'(gx) * WT_W'(gy);
      geom_in.weight[1]   = WT_W'(fx) * WT_W'(gy);
      geom_in.weight[2]   = WT_W'(gx) * WT_W'(fy);
      geom_in.weight[3]   = WT_W'(fx) * WT_W'(fy);
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

### rtl/core/p2br_blend.sv
// Multiply-accumulate of the four neighbours and scaling to 8-bit channels.
module p2br_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  p2br_pkg::blend_ctl_type        ctl,
   input  logic [p2br_pkg::PIX_W-1:0]     rd_data,
   input  p2br_pkg::weight_vec_type       weight,
   output p2br_pkg::pix_type              pix,
   output logic                           busy
);
   import p2br_pkg::*;

   logic [WT_W-1:0]   weight_sel;
   logic [MUL_W-1:0]  full [NCHAN];
   logic [ACC_W-1:0]  prod_in [NCHAN];
   logic [ACC_W-1:0]  prod_ff [NCHAN];
   logic              prod_vld_ff;
   logic [ACC_W-1:0]  acc_ff [NCHAN];
   logic [CHAN_W-1:0] norm [NCHAN];
   logic [CHAN_W-1:0] quot [NCHAN];
   logic [OUT_W-1:0]  res [NCHAN];

   // One product per channel for the neighbour that arrives this cycle
   always_comb begin
      weight_sel = weight[ctl.rd_tap];
      for (int c = 0; c < NCHAN; c++) begin
         full[c]    = MUL_W'(rd_data[c*CHAN_W +: CHAN_W]) * MUL_W'(weight_sel);
         prod_in[c] = full[c][ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.rd_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NCHAN; c++) begin
         prod_ff[c] <= prod_in[c];
         if (ctl.clear) begin
            acc_ff[c] <= '0;
         end else if (prod_vld_ff) begin
            acc_ff[c] <= acc_ff[c] + prod_ff[c];
         end
      end
   end

   // The weights sum to 2^shift, so the shifted sum fits a channel;
   // the quotient by 257 then follows from one subtract and two shifts.
   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         norm[c] = CHAN_W'(acc_ff[c] >> ctl.shift);
         quot[c] = (norm[c] - (norm[c] >> DIV_SHIFT)) >> DIV_SHIFT;
         res[c]  = (quot[c] > CHAN_W'(CHAN_MAX)) ? CHAN_MAX : OUT_W'(quot[c]);
      end
   end

   assign pix.red   = res[0];
   assign pix.green = res[1];
   assign pix.blue  = res[2];
   assign pix.alpha = res[3];
   assign busy      = prod_vld_ff;

endmodule

### rtl/core/pow2_bilinear_image_resampler_core.sv
// Top level of the power-of-two bilinear RGBA resampler: control, registers and flags.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  req_type: load or resample request
//   rsp_     out        rsp_valid/rsp_stall  rsp_type: 8-bit RGBA pixel and flags
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata (9 bits)
//
// A load item is written to the pixel memory at the edge that accepts it, so
// loads go at one item per cycle while no resample request is in progress.
// A resample request stalls the input from its acceptance through address
// and weight generation, four reads of the single-ported pixel memory (one
// neighbour per cycle), multiply and accumulate, and scaling and registering
// of the result; the input is open again once the sequencer is back in idle.
// A request outside the output size reads no neighbours.
// Reset is synchronous; the pixel memory is not cleared, and only pixels that
// were loaded may be read. A stalled result waits in the output register
// while further items are accepted; a new result waits until that slot frees.
module pow2_bilinear_image_resampler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  p2br_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output p2br_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [p2br_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [p2br_pkg::DIM_W-1:0]       csr_wdata
);
   import p2br_pkg::*;

   // Configuration registers
   logic [DIM_W-1:0] source_width_ff;
   logic [DIM_W-1:0] source_height_ff;
   logic             invert_alpha_ff;

   // Sequencer
   state_type        state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             rd_pend_ff;
   logic [TAP_W-1:0] rd_tap_ff;
   logic             rd_issue;
   logic             clear_acc;
   logic             fin_go;
   logic             pipe_empty;

   // Request coordinates held for the whole blend
   logic [POS_W-1:0] pos_x_ff;
   logic [POS_W-1:0] pos_y_ff;

   // Running alpha-class flags
   logic saw_trans_ff, saw_part_ff;
   logic saw_trans_new, saw_part_new;
   logic alpha_translucent, alpha_partial;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_wdata;
   logic [PIX_W-1:0]  ram_rdata;

   geom_type      geom;
   blend_ctl_type blend_ctl;
   pix_type       pix;
   logic          blend_busy;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Register writes are taken in any cycle; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= DIM_W'(MAX_WIDTH);
         source_height_ff <= DIM_W'(MAX_HEIGHT);
         invert_alpha_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_wdata;
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_wdata;
            CSR_INVERT_ALPHA:  invert_alpha_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_data.action == ACT_REQUEST)) begin
         pos_x_ff <= req_data.pos_x;
         pos_y_ff <= req_data.pos_y;
      end
   end

   // Pixel memory: loads write on acceptance, the sequencer reads neighbours.
   // Both only happen apart, the request sequence never runs in idle.
   assign ram_we    = req_accept && (req_data.action == ACT_LOAD) &&
                      ((DIM_W + 1)'(req_data.pos_x) < (DIM_W + 1)'(MAX_WIDTH)) &&
                      ((DIM_W + 1)'(req_data.pos_y) < (DIM_W + 1)'(MAX_HEIGHT));
   assign ram_wdata = {req_data.in_alpha, req_data.in_blue,
                       req_data.in_green, req_data.in_red};
   assign ram_addr  = (state_ff == ST_READ) ? geom.addr[tap_ff]
                                            : {YW'(req_data.pos_y), XW'(req_data.pos_x)};

   p2br_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_pixels (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   p2br_addr u_addr (
      .clock         (clock),
      .pos_x         (pos_x_ff),
      .pos_y         (pos_y_ff),
      .source_width  (source_width_ff),
      .source_height (source_height_ff),
      .geom          (geom)
   );

   assign blend_ctl.clear    = clear_acc;
   assign blend_ctl.rd_valid = rd_pend_ff;
   assign blend_ctl.rd_tap   = rd_tap_ff;
   assign blend_ctl.shift    = geom.shift;

   p2br_blend u_blend (
      .clock   (clock),
      .reset   (reset),
      .ctl     (blend_ctl),
      .rd_data (ram_rdata),
      .weight  (geom.weight),
      .pix     (pix),
      .busy    (blend_busy)
   );

   assign pipe_empty = !rd_pend_ff && !blend_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_ff     <= '0;
         rd_pend_ff <= 1'b0;
         rd_tap_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         tap_ff     <= tap_in;
         rd_pend_ff <= rd_issue;
         rd_tap_ff  <= tap_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      rd_issue  = 1'b0;
      clear_acc = 1'b0;
      fin_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.action == ACT_REQUEST)) begin
               state_in = ST_GEOM;
            end
         end
         ST_GEOM: begin
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            clear_acc = 1'b1;
            tap_in    = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // An out-of-range request reads nothing and goes straight on.
            if (geom.coord_error) begin
               state_in = ST_FINISH;
            end else begin
               rd_issue = 1'b1;
               tap_in   = tap_ff + TAP_W'(1);
               if (tap_ff == TAP_W'(TAPS - 1)) state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (pipe_empty && (!rsp_valid_ff || !rsp_stall)) begin
               fin_go   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Flags use the blended alpha before any inversion.
   always_comb begin
      alpha_translucent = !geom.coord_error && (pix.alpha != CHAN_MAX);
      alpha_partial     = alpha_translucent && (pix.alpha != '0);
      saw_trans_new     = saw_trans_ff || alpha_translucent;
      saw_part_new      = saw_part_ff || alpha_partial;

      rsp_data_in.has_cutout_alpha  = saw_trans_new && !saw_part_new;
      rsp_data_in.has_partial_alpha = saw_part_new;
      if (geom.coord_error) begin
         rsp_data_in.out_red       = '0;
         rsp_data_in.out_green     = '0;
         rsp_data_in.out_blue      = '0;
         rsp_data_in.out_alpha     = '0;
         rsp_data_in.is_last_pixel = 1'b0;
         rsp_data_in.coord_error   = 1'b1;
      end else begin
         rsp_data_in.out_red       = pix.red;
         rsp_data_in.out_green     = pix.green;
         rsp_data_in.out_blue      = pix.blue;
         rsp_data_in.out_alpha     = invert_alpha_ff ? (CHAN_MAX - pix.alpha) : pix.alpha;
         rsp_data_in.is_last_pixel = geom.is_last;
         rsp_data_in.coord_error   = 1'b0;
      end
      rsp_valid_in = fin_go || (rsp_valid_ff && rsp_stall);
   end

   // The last pixel of the output image closes a pass and clears the flags,
   // after its own result has shown them.
   always_ff @(posedge clock) begin
      if (reset) begin
         saw_trans_ff <= 1'b0;
         saw_part_ff  <= 1'b0;
      end else if (fin_go) begin
         if (rsp_data_in.is_last_pixel) begin
            saw_trans_ff <= 1'b0;
            saw_part_ff  <= 1'b0;
         end else begin
            saw_trans_ff <= saw_trans_new;
            saw_part_ff  <= saw_part_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A memory write never lands while a blend is reading neighbours.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("pixel write during a blend");

   // A result only appears when the finishing step loads it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fin_go))
      else $error("result appeared without a finished blend");

   // An out-of-range request carries zero colours and is never the last pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.coord_error) |->
         ((rsp_data_ff.out_red == '0) && (rsp_data_ff.out_green == '0) &&
          (rsp_data_ff.out_blue == '0) && (rsp_data_ff.out_alpha == '0) &&
          !rsp_data_ff.is_last_pixel))
      else $error("coordinate error result carries pixel data");

   // The two alpha classes are exclusive.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.has_cutout_alpha && rsp_data_ff.has_partial_alpha))
      else $error("cutout and partial alpha both reported");

   // The last pixel of a pass leaves both flags clear.
   assert property (@(posedge clock) disable iff (reset)
      (fin_go && rsp_data_in.is_last_pixel) |=> (!saw_trans_ff && !saw_part_ff))
      else $error("alpha flags survived the end of a pass");

endmodule
